// ===== design/iddt_pkg.sv =====
// shared constants and types for the indent/dedent token tracker
`default_nettype none
package iddt_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IND_W       = 16;
  localparam int KIND_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NEWLINE = 2'd0,
    KIND_INDENT  = 2'd1,
    KIND_DEDENT  = 2'd2
  } kind_t;

  // result of one pass through the shared indent comparator
  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_res_t;

endpackage
`default_nettype wire

// ===== design/iddt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module iddt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/iddt_cmp.sv =====
// shared indent comparator used for the top check and the dedent walk
`default_nettype none
module iddt_cmp (
  input  wire logic [iddt_pkg::IND_W-1:0] ind,
  input  wire logic [iddt_pkg::IND_W-1:0] entry,
  output iddt_pkg::cmp_res_t              res
);

  always_comb begin
    res.gt = (ind > entry);
    res.lt = (ind < entry);
  end

endmodule
`default_nettype wire

// ===== design/indent_dedent_token_tracker.sv =====
// top level of the indent/dedent token tracker
// usage:
//   input channel (in_valid/in_ready) carries one token request: the three
//   want flags plus the line measurement (line_crossed, at_end, line_indent).
//   output channel (out_valid/out_ready) returns exactly one result per
//   request: token_valid and token_kind (0 newline, 1 indent, 2 dedent).
//   one request is in flight at a time; in_ready is high only while idle.
// sequence:
//   a request dropped before any compare (nothing wanted, no line crossed,
//   repeated end) goes from decide straight to the result; owed tokens are
//   served or cleared in the serve state; a fresh line compare runs the
//   dedent walk between decide and serve, counting the dedents: the walk
//   reads one stack entry per cycle through the single comparator. the next
//   request is taken only once the result has gone and the tracker is idle.
// reset:
//   synchronous, active high; the stack holds only its base entry (indent 0),
//   all owed marks are clear and end of input has not been seen. stack ram
//   entries above the base are written before they are read, so no clearing.
// stall:
//   the result is held until out_ready; no new request is taken before then.
`default_nettype none
module indent_dedent_token_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           want_newline,
  input  wire logic                           want_indent,
  input  wire logic                           want_dedent,
  input  wire logic                           line_crossed,
  input  wire logic                           at_end,
  input  wire logic [iddt_pkg::IND_W-1:0]     line_indent,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                token_valid,
  output logic      [iddt_pkg::KIND_W-1:0]    token_kind
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_SERVE,
    S_OUT
  } state_t;

  state_t state;

  // latched request
  logic                        w_nl;
  logic                        w_in;
  logic                        w_de;
  logic                        crossed;
  logic                        end_req;
  logic [iddt_pkg::IND_W-1:0]  ind;

  // tracker state
  logic [iddt_pkg::CNT_W-1:0]  stack_depth;
  logic [iddt_pkg::IND_W-1:0]  pending_indent_value;
  logic [iddt_pkg::CNT_W-1:0]  dedents_owed;
  logic                        newline_owed;
  logic                        indent_owed;
  logic                        end_seen;

  // walk pointer: index of the stack entry being compared
  logic [iddt_pkg::CNT_W-1:0]  idx;
  logic                        first;

  logic [iddt_pkg::CNT_W-1:0]  depth_m1;
  logic [iddt_pkg::CNT_W-1:0]  idx_m1;
  logic [iddt_pkg::ADDR_W-1:0] raddr;
  logic [iddt_pkg::IND_W-1:0]  rdata;
  logic [iddt_pkg::IND_W-1:0]  entry;
  iddt_pkg::cmp_res_t          cmp;

  logic                        owed;
  logic                        any_want;
  logic                        room;
  logic                        srv_nl;
  logic                        srv_in;
  logic                        srv_de;
  logic                        push_we;

  assign in_ready = (state == S_IDLE);

  assign depth_m1 = stack_depth - iddt_pkg::CNT_W'(1);
  assign idx_m1   = idx - iddt_pkg::CNT_W'(1);

  // read address: stack top while deciding, next lower entry while walking
  assign raddr = (state == S_DECIDE) ? depth_m1[iddt_pkg::ADDR_W-1:0]
                                     : idx_m1[iddt_pkg::ADDR_W-1:0];

  // base entry is never written and always reads as indent 0
  assign entry = (idx == '0) ? '0 : rdata;

  assign owed     = newline_owed | indent_owed | (dedents_owed != '0);
  assign any_want = w_nl | w_in | w_de;
  assign room     = (stack_depth < iddt_pkg::CNT_W'(iddt_pkg::STACK_DEPTH));

  // priority of owed tokens: newline, then indent, then dedent
  assign srv_nl = newline_owed & w_nl;
  assign srv_in = !srv_nl & indent_owed & w_in;
  assign srv_de = !srv_nl & !srv_in & (dedents_owed != '0) & w_de;

  assign push_we = (state == S_SERVE) & srv_in & room;

  iddt_ram #(
    .WIDTH (iddt_pkg::IND_W),
    .DEPTH (iddt_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_we),
    .waddr (stack_depth[iddt_pkg::ADDR_W-1:0]),
    .wdata (pending_indent_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  iddt_cmp u_cmp (
    .ind   (ind),
    .entry (entry),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      out_valid            <= 1'b0;
      token_valid          <= 1'b0;
      token_kind           <= iddt_pkg::KIND_NEWLINE;
      stack_depth          <= iddt_pkg::CNT_W'(1);
      pending_indent_value <= '0;
      dedents_owed         <= '0;
      newline_owed         <= 1'b0;
      indent_owed          <= 1'b0;
      end_seen             <= 1'b0;
      first                <= 1'b0;
      idx                  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            w_nl    <= want_newline;
            w_in    <= want_indent;
            w_de    <= want_dedent;
            // end of input counts as a crossed line at indent 0
            crossed <= line_crossed | at_end;
            end_req <= at_end;
            ind     <= at_end ? '0 : line_indent;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (owed) begin
            state <= S_SERVE;
          end else if (!any_want || !crossed || (end_req && end_seen)) begin
            token_valid <= 1'b0;
            token_kind  <= iddt_pkg::KIND_NEWLINE;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else begin
            end_seen <= end_seen | end_req;
            idx      <= depth_m1;
            first    <= 1'b1;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          first <= 1'b0;
          if (first && cmp.gt) begin
            // deeper line
            if (w_in) begin
              indent_owed          <= 1'b1;
              pending_indent_value <= ind;
            end else begin
              newline_owed <= 1'b1;
            end
            state <= S_SERVE;
          end else begin
            if (first) begin
              newline_owed <= 1'b1;
            end
            // count one dedent per stack entry above the new indent
            if (cmp.lt) begin
              dedents_owed <= dedents_owed + iddt_pkg::CNT_W'(1);
              idx          <= idx_m1;
            end else begin
              state <= S_SERVE;
            end
          end
        end
        S_SERVE: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
          if (srv_nl) begin
            newline_owed <= 1'b0;
            token_valid  <= 1'b1;
            token_kind   <= iddt_pkg::KIND_NEWLINE;
          end else if (srv_in) begin
            newline_owed <= 1'b0;
            indent_owed  <= 1'b0;
            // full stack drops the push but still emits the token
            if (room) begin
              stack_depth <= stack_depth + iddt_pkg::CNT_W'(1);
            end
            token_valid <= 1'b1;
            token_kind  <= iddt_pkg::KIND_INDENT;
          end else if (srv_de) begin
            newline_owed <= 1'b0;
            dedents_owed <= dedents_owed - iddt_pkg::CNT_W'(1);
            if (stack_depth > iddt_pkg::CNT_W'(1)) begin
              stack_depth <= depth_m1;
            end
            token_valid <= 1'b1;
            token_kind  <= iddt_pkg::KIND_DEDENT;
          end else begin
            // nothing owed is wanted: drop all marks
            newline_owed <= 1'b0;
            indent_owed  <= 1'b0;
            dedents_owed <= '0;
            token_valid  <= 1'b0;
            token_kind   <= iddt_pkg::KIND_NEWLINE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/iddt_checker.sv =====
// port-level checks for the indent/dedent token tracker
`default_nettype none
module iddt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        token_valid,
  input wire logic [iddt_pkg::KIND_W-1:0] token_kind
);

  // one request at a time: never ready while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready high while a result is pending");

  // a taken request blocks the input until its result is transferred
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready again right after a transfer");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_kind == iddt_pkg::KIND_NEWLINE ||
                   token_kind == iddt_pkg::KIND_INDENT ||
                   token_kind == iddt_pkg::KIND_DEDENT))
    else $error("illegal token kind");

  a_no_token_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !token_valid) |-> (token_kind == iddt_pkg::KIND_NEWLINE))
    else $error("kind not zero on an empty result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(token_valid) && $stable(token_kind)))
    else $error("result changed while stalled");

endmodule

bind indent_dedent_token_tracker iddt_checker u_iddt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .token_valid (token_valid),
  .token_kind  (token_kind)
);
`default_nettype wire

// ===== test/indent_dedent_token_tracker_test.sv =====
// testbench for the indent/dedent token tracker: directed and random token requests
module indent_dedent_token_tracker_test;

  // cycles with no transfer on either channel before the run is given up
  localparam int WATCHDOG_LIMIT = 5000;
  // quiet cycles after the last result, well above the idle-path latency
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_PER_PHASE = 472;

  typedef struct packed {
    logic            valid;
    iddt_pkg::kind_t kind;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid     = 1'b0;
  logic                       want_newline = 1'b0;
  logic                       want_indent  = 1'b0;
  logic                       want_dedent  = 1'b0;
  logic                       line_crossed = 1'b0;
  logic                       at_end       = 1'b0;
  logic [iddt_pkg::IND_W-1:0] line_indent  = '0;
  logic                       out_ready    = 1'b0;

  wire                        in_ready;
  wire                        out_valid;
  wire                        token_valid;
  wire [iddt_pkg::KIND_W-1:0] token_kind;

  indent_dedent_token_tracker i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .want_newline (want_newline),
    .want_indent  (want_indent),
    .want_dedent  (want_dedent),
    .line_crossed (line_crossed),
    .at_end       (at_end),
    .line_indent  (line_indent),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_valid  (token_valid),
    .token_kind   (token_kind)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the tracker state
  // ---------------------------------------------------------------------------
  // strictly rising open indents
  logic [iddt_pkg::IND_W-1:0] open_levels [iddt_pkg::STACK_DEPTH];
  int unsigned                open_count;   // entries in use, base included
  logic [iddt_pkg::IND_W-1:0] push_indent;  // indent pushed when INDENT is served
  int unsigned                dedent_debt;  // DEDENT tokens still owed
  bit                         newline_debt;
  bit                         indent_debt;
  bit                         end_handled;  // end of input already handled

  token_t expected_tokens[$];               // one per accepted request, in order
  int     mismatch_count = 0;

  // percent chance per cycle that the sender / receiver sits idle
  int send_idle_pct = 6;
  int recv_idle_pct = 54;

  function automatic void drop_debts();
    newline_debt = 1'b0;
    indent_debt  = 1'b0;
    dedent_debt  = 0;
  endfunction

  // serve the first owed token that the parser wants; 0 if none is wanted
  function automatic bit serve_debt(input bit wn, input bit wi, input bit wd,
                                    output iddt_pkg::kind_t kind);
    kind = iddt_pkg::KIND_NEWLINE;
    if (newline_debt && wn) begin
      newline_debt = 1'b0;
      return 1'b1;
    end
    if (indent_debt && wi) begin
      newline_debt = 1'b0;
      indent_debt  = 1'b0;
      // a full stack still emits INDENT but loses the push
      if (open_count < iddt_pkg::STACK_DEPTH) begin
        open_levels[iddt_pkg::ADDR_W'(open_count)] = push_indent;
        open_count++;
      end
      kind = iddt_pkg::KIND_INDENT;
      return 1'b1;
    end
    if (dedent_debt > 0 && wd) begin
      newline_debt = 1'b0;
      dedent_debt--;
      // the base entry is never popped
      if (open_count > 1) open_count--;
      kind = iddt_pkg::KIND_DEDENT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic token_t next_token(input bit wn, input bit wi, input bit wd,
                                        input bit crossed, input bit eof,
                                        input logic [iddt_pkg::IND_W-1:0] ind);
    token_t                     tok;
    iddt_pkg::kind_t            kind;
    bit                         served;
    logic [iddt_pkg::IND_W-1:0] top;
    int unsigned                walk;
    int unsigned                count;
    tok.valid = 1'b0;
    tok.kind  = iddt_pkg::KIND_NEWLINE;
    served    = 1'b0;
    if (newline_debt || indent_debt || dedent_debt > 0) begin
      // owed tokens go first; the measurement is ignored
      served = serve_debt(wn, wi, wd, kind);
      if (!served) drop_debts();
    end else if (wn || wi || wd) begin
      // end of input is a crossed line at indent zero
      if (eof) begin
        crossed = 1'b1;
        ind     = '0;
      end
      if (!crossed) return tok;
      if (eof) begin
        if (end_handled) return tok;
        end_handled = 1'b1;
      end
      top = open_levels[iddt_pkg::ADDR_W'(open_count - 1)];
      if (ind > top) begin
        if (wi) begin
          indent_debt = 1'b1;
          push_indent = ind;
        end else begin
          newline_debt = 1'b1;
        end
      end else begin
        newline_debt = 1'b1;
        if (ind < top) begin
          count = 0;
          walk  = open_count;
          while (walk > 1 && ind < open_levels[iddt_pkg::ADDR_W'(walk - 1)]) begin
            count++;
            walk--;
          end
          dedent_debt = count;
        end
      end
      served = serve_debt(wn, wi, wd, kind);
      if (!served) drop_debts();
    end
    if (served) begin
      tok.valid = 1'b1;
      tok.kind  = kind;
    end
    return tok;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request transfer; valid stays high across back-to-back requests
  task automatic send_request(input bit wn, input bit wi, input bit wd,
                              input bit crossed, input bit eof,
                              input logic [iddt_pkg::IND_W-1:0] ind);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    want_newline <= wn;
    want_indent  <= wi;
    want_dedent  <= wd;
    line_crossed <= crossed;
    at_end       <= eof;
    line_indent  <= ind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_tokens.push_back(next_token(wn, wi, wd, crossed, eof, ind));
  endtask

  // hold the sender off until every pending result has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    token_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token result transfer with no request pending");
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (token_valid !== want.valid) begin
          $error("token_valid: expected %0d, got %0d", want.valid, token_valid);
          mismatch_count++;
        end
        if (token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no transfer at all
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // requests that give no token, or only a newline, and leave the stack alone
  task automatic test_no_token_cases();
    send_request(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd5);      // nothing wanted, nothing owed
    send_request(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'd8);      // no line crossed
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0);      // equal line: newline
    send_request(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0);      // newline owed but unwanted
  endtask

  // deeper and shallower lines, unwanted owed tokens
  task automatic test_indent_dedent();
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd4);      // indent, stack 0 4
    send_request(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'd8);      // deeper, indent unwanted
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd8);      // indent, stack 0 4 8
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF);   // widest indent
    send_request(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0);      // newline, three dedents owed
    send_request(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0);      // dedent
    send_request(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd3);      // owed but nothing wanted: cleared
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd2);      // off-grid dedent, newline first
    send_request(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'd2);      // owed dedent, measurement ignored
    send_request(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd6);      // owed dedent, measurement ignored
    send_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 16'hAAAA);   // indent with alternating bits
    send_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 16'h5555);   // shallower, newline unwanted
  endtask

  // end of input forces indent zero and is handled only once
  task automatic test_end_of_input();
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd12);     // indent
    send_request(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFF);   // end: newline, dedent owed
    send_request(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0);      // dedent
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0);      // second end: nothing
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0);      // still tracking after end
  endtask

  // fill the stack, push once more, then unwind it in one line
  task automatic test_full_stack();
    for (int lvl = 1; lvl <= iddt_pkg::STACK_DEPTH; lvl++) begin
      send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, lvl[iddt_pkg::IND_W-1:0]);
    end
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0);      // long dedent count
    for (int n = 1; n < iddt_pkg::STACK_DEPTH; n++) begin
      send_request(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
    end
    send_request(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0);      // nothing left owed
  endtask

  // mostly well-formed source lines: all tokens wanted, indents near the stack
  task automatic test_random_lines(input int count);
    bit                         wn, wi, wd, crossed, eof;
    logic [iddt_pkg::IND_W-1:0] ind;
    logic [iddt_pkg::IND_W-1:0] top;
    int                         pick;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) pause_until_drained();
      if ($urandom_range(0, 99) < 75) begin
        {wn, wi, wd} = 3'b111;
      end else begin
        {wn, wi, wd} = 3'($urandom_range(0, 7));
      end
      crossed = ($urandom_range(0, 99) < 85);
      eof     = ($urandom_range(0, 99) < 3);
      top     = open_levels[iddt_pkg::ADDR_W'(open_count - 1)];
      pick    = $urandom_range(0, 99);
      if (pick < 35) begin
        ind = top;
      end else if (pick < 60) begin
        ind = top + iddt_pkg::IND_W'($urandom_range(1, 8));
      end else if (pick < 85) begin
        ind = open_levels[iddt_pkg::ADDR_W'($urandom_range(0, open_count - 1))];
        if ($urandom_range(0, 3) == 0) ind = ind + iddt_pkg::IND_W'(1);
      end else if (pick < 95) begin
        ind = iddt_pkg::IND_W'($urandom_range(0, 64));
      end else begin
        ind = iddt_pkg::IND_W'($urandom_range(0, 65535));
      end
      send_request(wn, wi, wd, crossed, eof, ind);
    end
  endtask

  initial begin
    for (int e = 0; e < iddt_pkg::STACK_DEPTH; e++) begin
      open_levels[iddt_pkg::ADDR_W'(e)] = '0;
    end
    open_count  = 1;
    push_indent = '0;
    drop_debts();
    end_handled = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_token_cases();
    test_indent_dedent();
    test_end_of_input();
    test_full_stack();
    pause_until_drained();

    // slow receiver
    test_random_lines(RANDOM_PER_PHASE);
    // slow sender
    send_idle_pct = 54;
    recv_idle_pct = 6;
    test_random_lines(RANDOM_PER_PHASE);
    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(RANDOM_PER_PHASE);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/iddt_pkg.sv
design/iddt_ram.sv
design/iddt_cmp.sv
design/indent_dedent_token_tracker.sv
design/iddt_checker.sv
test/indent_dedent_token_tracker_test.sv
